// ----- sv/bts_pkg.sv -----
// shared types, codes and helpers for the beaver triple share multiplier
// no dependencies; used by the top level and its port checker
package bts_pkg;

	localparam int unsigned WORD_W         = 32;
	localparam int unsigned FUNC_W         = 2;
	localparam int unsigned STATUS_W       = 3;
	localparam int unsigned LEFT_W         = 11;
	localparam int unsigned KBITS_W        = 6;
	localparam int unsigned CFG_IDX_W      = 1;
	localparam int unsigned CFG_DATA_W     = 6;
	localparam int unsigned IN_TDATA_W     = 8 * WORD_W;
	localparam int unsigned OUT_TDATA_RAW  = 3 * WORD_W + LEFT_W;
	localparam int unsigned OUT_TDATA_W    = ((OUT_TDATA_RAW + 7) / 8) * 8;
	localparam int unsigned IN_TUSER_W     = 8;
	localparam int unsigned OUT_TUSER_W    = 8;
	localparam int unsigned TRIPLE_DEPTH_DEF = 1024;

	// function codes carried in tuser
	localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_OPEN   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_SELECT = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] STAT_OK              = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_EXHAUSTED       = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_NONE_PENDING    = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_ALREADY_PENDING = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_FULL            = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PARTY_ROLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHARE_BITS = 1'd1;

	// ring mask for k bits; above 32 acts as 32, zero acts as 1
	function automatic logic [WORD_W-1:0] ring_mask(input logic [KBITS_W-1:0] k);
		logic [WORD_W-1:0] m;
		begin
			if (k >= KBITS_W'(WORD_W)) begin
				m = '1;
			end else if (k == '0) begin
				m = WORD_W'(1);
			end else begin
				m = (WORD_W'(1) << k[4:0]) - WORD_W'(1);
			end
			return m;
		end
	endfunction

endpackage

// ----- sv/beaver_triple_share_multiplier.sv -----
// beaver triple share multiplier, one party of two-party additive sharing mod 2^k
// depends on bts_pkg; one shared 32x32 multiplier under a small sequencer
// sequence to the result transaction: load idle, emit; open/select idle, read, emit;
// finish idle, mul_a, mul_b, mul_c, sum, emit (three products through the one multiplier
// plus a final sum); a refused item idle, emit; the next item waits until back in idle
// arst_n clears control state, counters and held values; the triple store is not cleared
module beaver_triple_share_multiplier #(
	parameter int unsigned TRIPLE_DEPTH = bts_pkg::TRIPLE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bts_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bts_pkg::CFG_DATA_W-1:0]     cfg_data,
	// input stream
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// share_x, share_y, share_cond, triple_a, triple_b, triple_c, peer_d, peer_e
	input  logic [bts_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// func, zero fill
	input  logic [bts_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
	// result stream
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// open_d, open_e, product_share, triples_left, zero fill
	output logic [bts_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// status, zero fill
	output logic [bts_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);

	localparam int unsigned W      = bts_pkg::WORD_W;
	localparam int unsigned IDX_W  = (TRIPLE_DEPTH > 1) ? $clog2(TRIPLE_DEPTH) : 1;
	localparam int unsigned CNT_W  = $clog2(TRIPLE_DEPTH + 1);
	localparam int unsigned DIFF_W = (CNT_W > bts_pkg::LEFT_W) ? CNT_W : bts_pkg::LEFT_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_MUL_A,
		S_MUL_B,
		S_MUL_C,
		S_SUM,
		S_EMIT
	} state_t;

	state_t state_q;

	// configuration registers
	logic                          party_role_q;
	logic [bts_pkg::KBITS_W-1:0]   share_bits_q;

	// engine state
	logic [CNT_W-1:0]              loaded_q;
	logic [CNT_W-1:0]              use_q;
	logic [bts_pkg::FUNC_W-1:0]    pending_q;
	logic [W-1:0]                  held_a_q, held_b_q, held_c_q;
	logic [W-1:0]                  own_d_q, own_e_q, kept_else_q;

	// per-item work registers
	logic [bts_pkg::FUNC_W-1:0]    func_q;
	logic [W-1:0]                  opx_q, opy_q;
	logic [W-1:0]                  dd_q, ee_q;
	logic [W-1:0]                  prod_q;
	logic [W-1:0]                  acc_q;

	// result waiting for the output register
	logic [W-1:0]                  res_d_q, res_e_q, res_p_q;
	logic [bts_pkg::STATUS_W-1:0]  res_st_q;

	// output register
	logic                          m_valid_q;
	logic [W-1:0]                  out_d_q, out_e_q, out_p_q;
	logic [bts_pkg::STATUS_W-1:0]  out_st_q;
	logic [bts_pkg::LEFT_W-1:0]    out_left_q;

	// triple store {c, b, a}, one write and one registered read port
	logic [3*W-1:0]                mem_q [TRIPLE_DEPTH];
	logic [3*W-1:0]                rdata_q;
	logic                          mem_we;
	logic [3*W-1:0]                mem_wdata;

	// unpacked input fields
	logic [bts_pkg::FUNC_W-1:0]    in_func;
	logic [W-1:0]                  in_x, in_y, in_cond, in_a, in_b, in_c, in_pd, in_pe;

	logic [W-1:0]                  ring_m;
	logic                          in_accept;
	logic                          out_free;
	logic [DIFF_W-1:0]             left_diff;

	// shared multiplier
	logic [W-1:0]                  mul_p, mul_q, mul_r;

	assign in_func = s_axis_tuser[bts_pkg::FUNC_W-1:0];
	assign in_x    = s_axis_tdata[0*W +: W];
	assign in_y    = s_axis_tdata[1*W +: W];
	assign in_cond = s_axis_tdata[2*W +: W];
	assign in_a    = s_axis_tdata[3*W +: W];
	assign in_b    = s_axis_tdata[4*W +: W];
	assign in_c    = s_axis_tdata[5*W +: W];
	assign in_pd   = s_axis_tdata[6*W +: W];
	assign in_pe   = s_axis_tdata[7*W +: W];

	assign ring_m        = bts_pkg::ring_mask(share_bits_q);
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign cfg_ready     = 1'b1;
	assign left_diff     = DIFF_W'(loaded_q) - DIFF_W'(use_q);

	// a load that fits goes straight into the store at accept
	assign mem_we    = in_accept && (in_func == bts_pkg::FUNC_LOAD)
	                   && (loaded_q != CNT_W'(TRIPLE_DEPTH));
	assign mem_wdata = {in_c & ring_m, in_b & ring_m, in_a & ring_m};

	// operand select for the shared multiplier
	always_comb begin
		unique case (state_q)
			S_MUL_A: begin
				mul_p = held_a_q;
				mul_q = ee_q;
			end
			S_MUL_B: begin
				mul_p = held_b_q;
				mul_q = dd_q;
			end
			S_MUL_C: begin
				mul_p = dd_q;
				mul_q = ee_q;
			end
			default: begin
				mul_p = '0;
				mul_q = '0;
			end
		endcase
	end

	// low word of the product only, the ring is at most 32 bits
	assign mul_r = mul_p * mul_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[loaded_q[IDX_W-1:0]] <= mem_wdata;
		end
		rdata_q <= mem_q[use_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			party_role_q <= 1'b0;
			share_bits_q <= bts_pkg::KBITS_W'(W);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bts_pkg::REG_PARTY_ROLE: party_role_q <= cfg_data[0];
				bts_pkg::REG_SHARE_BITS: share_bits_q <= cfg_data[bts_pkg::KBITS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			loaded_q    <= '0;
			use_q       <= '0;
			pending_q   <= bts_pkg::FUNC_LOAD;
			held_a_q    <= '0;
			held_b_q    <= '0;
			held_c_q    <= '0;
			own_d_q     <= '0;
			own_e_q     <= '0;
			kept_else_q <= '0;
			func_q      <= bts_pkg::FUNC_LOAD;
			opx_q       <= '0;
			opy_q       <= '0;
			dd_q        <= '0;
			ee_q        <= '0;
			prod_q      <= '0;
			acc_q       <= '0;
			res_d_q     <= '0;
			res_e_q     <= '0;
			res_p_q     <= '0;
			res_st_q    <= bts_pkg::STAT_OK;
			m_valid_q   <= 1'b0;
			out_d_q     <= '0;
			out_e_q     <= '0;
			out_p_q     <= '0;
			out_st_q    <= bts_pkg::STAT_OK;
			out_left_q  <= '0;
		end else begin
			// the downstream side took the result; in S_EMIT a new one may take its place
			if (m_valid_q && m_axis_tready && (state_q != S_EMIT)) begin
				m_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						func_q   <= in_func;
						res_d_q  <= '0;
						res_e_q  <= '0;
						res_p_q  <= '0;
						res_st_q <= bts_pkg::STAT_OK;
						state_q  <= S_EMIT;
						unique case (in_func)
							bts_pkg::FUNC_LOAD: begin
								if (loaded_q == CNT_W'(TRIPLE_DEPTH)) begin
									res_st_q <= bts_pkg::STAT_FULL;
								end else begin
									loaded_q <= loaded_q + CNT_W'(1);
								end
							end
							bts_pkg::FUNC_OPEN, bts_pkg::FUNC_SELECT: begin
								if (pending_q != bts_pkg::FUNC_LOAD) begin
									res_st_q <= bts_pkg::STAT_ALREADY_PENDING;
								end else if (use_q >= loaded_q) begin
									res_st_q <= bts_pkg::STAT_EXHAUSTED;
								end else begin
									// store read of the next triple is under way
									use_q   <= use_q + CNT_W'(1);
									state_q <= S_READ;
									if (in_func == bts_pkg::FUNC_SELECT) begin
										opx_q       <= in_cond;
										opy_q       <= in_y - in_x;
										kept_else_q <= in_x & ring_m;
									end else begin
										opx_q <= in_x;
										opy_q <= in_y;
									end
								end
							end
							bts_pkg::FUNC_FINISH: begin
								if (pending_q == bts_pkg::FUNC_LOAD) begin
									res_st_q <= bts_pkg::STAT_NONE_PENDING;
								end else begin
									// reconstruct d and e, seed the sum with c and kept value
									dd_q    <= (own_d_q + in_pd) & ring_m;
									ee_q    <= (own_e_q + in_pe) & ring_m;
									acc_q   <= held_c_q + ((pending_q == bts_pkg::FUNC_SELECT)
									           ? kept_else_q : '0);
									state_q <= S_MUL_A;
								end
							end
							default: ;
						endcase
					end
				end
				S_READ: begin
					held_a_q  <= rdata_q[0*W +: W];
					held_b_q  <= rdata_q[1*W +: W];
					held_c_q  <= rdata_q[2*W +: W];
					own_d_q   <= (opx_q - rdata_q[0*W +: W]) & ring_m;
					own_e_q   <= (opy_q - rdata_q[1*W +: W]) & ring_m;
					res_d_q   <= (opx_q - rdata_q[0*W +: W]) & ring_m;
					res_e_q   <= (opy_q - rdata_q[1*W +: W]) & ring_m;
					pending_q <= func_q;
					state_q   <= S_EMIT;
				end
				S_MUL_A: begin
					prod_q  <= mul_r;
					state_q <= S_MUL_B;
				end
				S_MUL_B: begin
					prod_q  <= mul_r;
					acc_q   <= acc_q + prod_q;
					state_q <= S_MUL_C;
				end
				S_MUL_C: begin
					prod_q  <= mul_r;
					acc_q   <= acc_q + prod_q;
					state_q <= S_SUM;
				end
				S_SUM: begin
					// the d*e term belongs to party 0 only
					res_p_q   <= (acc_q + (party_role_q ? '0 : prod_q)) & ring_m;
					pending_q <= bts_pkg::FUNC_LOAD;
					state_q   <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						m_valid_q  <= 1'b1;
						out_d_q    <= res_d_q;
						out_e_q    <= res_e_q;
						out_p_q    <= res_p_q;
						out_st_q   <= res_st_q;
						out_left_q <= left_diff[bts_pkg::LEFT_W-1:0];
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = bts_pkg::OUT_TDATA_W'({out_left_q, out_p_q, out_e_q, out_d_q});
	assign m_axis_tuser  = bts_pkg::OUT_TUSER_W'(out_st_q);

endmodule

// ----- sv/bts_checker.sv -----
// port-level checker for the beaver triple share multiplier
// depends on bts_pkg; bound to the top level below
module bts_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [bts_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [bts_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

	localparam int unsigned W = bts_pkg::WORD_W;

	logic [bts_pkg::STATUS_W-1:0] st;
	assign st = m_axis_tuser[bts_pkg::STATUS_W-1:0];

	// an accepted item keeps the engine busy for at least the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready right after an accepted transaction");

	// status codes stay within the defined set
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (st <= bts_pkg::STAT_FULL))
		else $error("undefined status code");

	// a failed item carries no shares
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (st != bts_pkg::STAT_OK) |->
		(m_axis_tdata[3*W-1:0] == '0))
		else $error("nonzero shares on a failed transaction");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

endmodule

bind beaver_triple_share_multiplier bts_checker u_bts_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
